@@ design/ms_pkg.sv @@
// Shared constants and types for the min-tracking stack.
package ms_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] min_value;
    logic                     has_min;
    logic [1:0]               status;
  } result_t;

endpackage

@@ design/ms_if.sv @@
// Request and response channel interfaces.
interface ms_req_if;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic signed [31:0]       value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface ms_rsp_if;
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       min_value;
  logic                     has_min;
  logic [1:0]               status;

  modport source (output valid, min_value, has_min, status, input ready);
  modport sink   (input valid, min_value, has_min, status, output ready);
endinterface

@@ design/ms_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
module ms_ram #(
  parameter int AW = 8,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/ms_outbuf.sv @@
// Response register with a skid slot.
module ms_outbuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  input  ms_pkg::result_t  res,
  output logic             space,
  ms_rsp_if.source         rsp
);
  import ms_pkg::*;

  logic    out_valid;
  logic    skid_valid;
  result_t out_data;
  result_t skid_data;
  logic    take;

  assign take  = out_valid && rsp.ready;
  assign space = !skid_valid;

  assign rsp.valid     = out_valid;
  assign rsp.min_value = out_data.min_value;
  assign rsp.has_min   = out_data.has_min;
  assign rsp.status    = out_data.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        // advance the skid entry, refill it when a new result arrives
        out_data   <= skid_data;
        skid_valid <= res_valid;
        if (res_valid) begin
          skid_data <= res;
        end
      end else if (res_valid) begin
        out_data <= res;
      end else begin
        // drain
        out_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid) begin
        out_data  <= res;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= res;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule

@@ design/ms_core.sv @@
// Stack control: cached tops, counts and the two stack memories.
module ms_core (
  input  logic             clk,
  input  logic             rst,
  ms_req_if.sink           req,
  input  logic             space,
  output logic             res_valid,
  output ms_pkg::result_t  res
);
  import ms_pkg::*;

  typedef enum logic {S_IDLE, S_LOAD} state_t;

  state_t                   state;
  logic [CNT_W-1:0]         vc;
  logic [CNT_W-1:0]         mc;
  logic signed [DATA_W-1:0] val_top;
  logic signed [DATA_W-1:0] min_top;
  logic                     popped_min;

  logic                     accept;
  logic                     is_push;
  logic                     full;
  logic                     vempty;
  logic                     mempty;
  logic                     push_min;
  logic                     pop_min;
  logic                     vwe;
  logic                     mwe;
  logic [ADDR_W-1:0]        vraddr;
  logic [ADDR_W-1:0]        mraddr;
  logic [DATA_W-1:0]        v_rdata;
  logic [DATA_W-1:0]        m_rdata;
  logic signed [DATA_W-1:0] min_next;

  assign req.ready = (state == S_IDLE) && space;
  assign accept    = req.valid && req.ready;
  assign is_push   = (req.kind == KIND_PUSH);
  assign full      = (vc == CNT_W'(STACK_DEPTH));
  assign vempty    = (vc == '0);
  assign mempty    = (mc == '0);
  assign push_min  = mempty || (req.value <= min_top);
  assign pop_min   = !mempty && (min_top == val_top);

  assign vwe    = accept && is_push && !full;
  assign mwe    = vwe && push_min;
  // the entry below the top becomes the new top on a pop
  assign vraddr = ADDR_W'(vc - CNT_W'(2));
  assign mraddr = ADDR_W'(mc - CNT_W'(2));

  assign min_next = popped_min ? $signed(m_rdata) : min_top;

  ms_ram #(.AW(ADDR_W), .DW(DATA_W)) u_val_ram (
    .clk   (clk),
    .we    (vwe),
    .waddr (vc[ADDR_W-1:0]),
    .wdata (req.value),
    .raddr (vraddr),
    .rdata (v_rdata)
  );

  ms_ram #(.AW(ADDR_W), .DW(DATA_W)) u_min_ram (
    .clk   (clk),
    .we    (mwe),
    .waddr (mc[ADDR_W-1:0]),
    .wdata (req.value),
    .raddr (mraddr),
    .rdata (m_rdata)
  );

  always_comb begin
    res_valid     = 1'b0;
    res.min_value = '0;
    res.has_min   = 1'b0;
    res.status    = STATUS_OK;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (is_push) begin
            res_valid   = 1'b1;
            res.has_min = 1'b1;
            if (full) begin
              res.status    = STATUS_FULL;
              res.min_value = mempty ? '0 : min_top;
            end else begin
              res.min_value = push_min ? req.value : min_top;
            end
          end else if (vempty) begin
            res_valid  = 1'b1;
            res.status = STATUS_EMPTY;
          end
        end
      end
      S_LOAD: begin
        res_valid     = 1'b1;
        res.min_value = mempty ? '0 : min_next;
        res.has_min   = !vempty;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      vc    <= '0;
      mc    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_push) begin
              if (!full) begin
                vc      <= vc + CNT_W'(1);
                val_top <= req.value;
                if (push_min) begin
                  mc      <= mc + CNT_W'(1);
                  min_top <= req.value;
                end
              end
            end else if (!vempty) begin
              vc         <= vc - CNT_W'(1);
              popped_min <= pop_min;
              if (pop_min) begin
                mc <= mc - CNT_W'(1);
              end
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          // reload the cached tops from memory
          val_top <= $signed(v_rdata);
          min_top <= min_next;
          state   <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/min_tracking_stack.sv @@
// Min-tracking stack top level.
// Push, and pop of an empty stack: accepted while idle with a response slot free; the
// result is registered into the output buffer. One per cycle while a slot stays free.
// Pop of a non-empty stack: passes through S_IDLE and then S_LOAD, where the cached tops
// reload from the registered reads of the stack memories; no request is taken in S_LOAD.
// Reset clears the counts, state and response slots; memory contents are not
// cleared and need no clearing pass.
module min_tracking_stack (
  input  logic     clk,
  input  logic     rst,
  ms_req_if.sink   req,
  ms_rsp_if.source rsp
);
  import ms_pkg::*;

  logic    space;
  logic    res_valid;
  result_t res;

  ms_core u_core (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .space     (space),
    .res_valid (res_valid),
    .res       (res)
  );

  ms_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .space     (space),
    .rsp       (rsp)
  );

  // a result never arrives while both response slots are full
  assert property (@(posedge clk) disable iff (rst) res_valid |-> space)
    else $error("result produced with no response slot free");

  // a pop holds off the next request while the tops reload
  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.kind == KIND_POP && rsp.valid == 1'b0 &&
     !(res_valid && res.status == STATUS_EMPTY)) |=> !req.ready)
    else $error("request accepted during top reload");

  // reset empties the response path
  assert property (@(posedge clk) rst |=> !rsp.valid)
    else $error("response valid after reset");

endmodule

@@ tb/sv/min_stack_checker.sv @@
// Response checker for the min-tracking stack: predicts each response and compares it.
module min_stack_checker (
  input  logic clk,
  input  logic rst,
  ms_req_if    req,
  ms_rsp_if    rsp,
  output int   errors,
  output int   pending
);
  import ms_pkg::*;

  logic signed [DATA_W-1:0] value_stack [STACK_DEPTH];
  logic signed [DATA_W-1:0] min_stack   [STACK_DEPTH];
  int      value_depth;
  int      min_depth;
  result_t due_results [$];
  result_t want;
  int      accepted;
  int      answered;

  assign pending = accepted - answered;

  // Apply one request to the shadow stacks and return the response it should give.
  function automatic result_t apply_request(input logic op, input logic signed [DATA_W-1:0] v);
    result_t r;
    r.status = STATUS_OK;
    if (op == KIND_PUSH) begin
      if (value_depth >= STACK_DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        value_stack[value_depth] = v;
        value_depth++;
        if (min_depth == 0 || v <= min_stack[min_depth-1]) begin
          min_stack[min_depth] = v;
          min_depth++;
        end
      end
    end else if (value_depth == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      // the minimum leaves only when the popped value is the current minimum
      if (min_depth > 0 && min_stack[min_depth-1] == value_stack[value_depth-1]) min_depth--;
      value_depth--;
    end
    r.min_value = (min_depth > 0) ? min_stack[min_depth-1] : '0;
    r.has_min   = (value_depth > 0);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic signed [DATA_W-1:0] got,
                                 input logic signed [DATA_W-1:0] exp_val);
    if (errors < 40)
      $display("min_stack_checker: response %0d: %s got %0d expected %0d",
               answered, what, got, exp_val);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      value_depth = 0;
      min_depth   = 0;
      due_results.delete();
      accepted <= 0;
      answered <= 0;
    end else begin
      // check the response first: a request taken at this edge cannot answer at this edge
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        if (due_results.size() == 0) begin
          report_mismatch("response with no request outstanding, min_value", rsp.min_value, 0);
        end else begin
          want = due_results.pop_front();
          answered <= answered + 1;
          if (rsp.min_value !== want.min_value)
            report_mismatch("min_value", rsp.min_value, want.min_value);
          if (rsp.has_min !== want.has_min)
            report_mismatch("has_min", {31'd0, rsp.has_min}, {31'd0, want.has_min});
          if (rsp.status !== want.status)
            report_mismatch("status", {30'd0, rsp.status}, {30'd0, want.status});
        end
      end
      if (req.valid === 1'b1 && req.ready === 1'b1) begin
        due_results.push_back(apply_request(req.kind, req.value));
        accepted <= accepted + 1;
      end
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
// Top of the min-tracking stack testbench: clock, reset, requests, response pacing, verdict.
module tb_top;
  import ms_pkg::*;

  localparam int TOTAL_ITEMS = 1350;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 10;
  localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [31:0] MOST_POS = 32'sh7FFF_FFFF;

  typedef enum int {VAL_ANY, VAL_NEAR_ZERO, VAL_EXTREME, VAL_FALLING} value_style_t;
  typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED} segment_t;
  typedef enum int {RX_OPEN, RX_MOSTLY, RX_HALF, RX_SLOW} rx_mode_t;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   cycle_count;
  int   items_sent;
  int   burst_left;
  int   stack_fill;
  int   holdoffs_asked;
  int   holdoffs_done;
  logic signed [31:0] last_pushed;

  ms_req_if req_ch();
  ms_rsp_if rsp_ch();

  min_tracking_stack dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  min_stack_checker stack_check (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .errors  (fail_count),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_value(input value_style_t style);
    value_style_t s;
    s = ($urandom_range(0, 9) < 3) ? value_style_t'($urandom_range(0, 3)) : style;
    case (s)
      VAL_NEAR_ZERO: return $signed($urandom_range(0, 8)) - 4;
      VAL_EXTREME: begin
        case ($urandom_range(0, 6))
          0: return MOST_NEG;
          1: return MOST_NEG + 1;
          2: return -1;
          3: return 0;
          4: return 1;
          5: return MOST_POS - 1;
          default: return MOST_POS;
        endcase
      end
      // step down from the last pushed value to build a deep run of minima
      VAL_FALLING: return last_pushed - 32'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  // Offer one request, with bursts and gaps; return at the edge that takes it.
  task automatic offer(input logic op, input logic signed [31:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
    end
    burst_left--;
    req_ch.valid <= 1'b1;
    req_ch.kind  <= op;
    req_ch.value <= v;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    items_sent++;
    if (op == KIND_PUSH) begin
      if (stack_fill < STACK_DEPTH) stack_fill++;
      last_pushed = v;
    end else if (stack_fill > 0) begin
      stack_fill--;
    end
  endtask

  task automatic hold_until_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Response side: random pacing, plus a long hold-off whenever one is asked for.
  initial begin
    rx_mode_t mode;
    int       run;
    rsp_ch.ready <= 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      run  = $urandom_range(10, 80);
      repeat (run) begin
        @(posedge clk);
        case (mode)
          RX_OPEN:   rsp_ch.ready <= 1'b1;
          RX_MOSTLY: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_HALF:   rsp_ch.ready <= $urandom_range(0, 1);
          default:   rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
      if (holdoffs_asked != holdoffs_done) begin
        @(posedge clk);
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holdoffs_done++;
      end
    end
  end

  initial begin
    segment_t     seg;
    value_style_t style;
    int           seg_no;
    int           pct;
    req_ch.valid <= 1'b0;
    req_ch.kind  <= KIND_PUSH;
    req_ch.value <= '0;
    rst <= 1'b1;
    burst_left = 0;
    stack_fill = 0;
    last_pushed = 0;
    items_sent = 0;
    holdoffs_asked = 0;
    holdoffs_done = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty pops, duplicate minima, extremes, pop value ignored
    offer(KIND_POP, 0);
    offer(KIND_PUSH, 5);
    offer(KIND_PUSH, 7);
    offer(KIND_PUSH, 5);
    offer(KIND_PUSH, MOST_POS);
    offer(KIND_PUSH, MOST_NEG);
    offer(KIND_PUSH, MOST_NEG);
    offer(KIND_PUSH, 0);
    offer(KIND_POP, 32'sh5555_5555);
    offer(KIND_POP, 32'shAAAA_AAAA);
    offer(KIND_POP, 0);
    offer(KIND_POP, MOST_NEG);
    offer(KIND_POP, 0);
    offer(KIND_POP, -1);
    offer(KIND_POP, 0);
    offer(KIND_POP, 0);
    offer(KIND_PUSH, -1);
    offer(KIND_PUSH, MOST_NEG + 1);
    offer(KIND_PUSH, MOST_POS - 1);
    offer(KIND_POP, MOST_POS);
    offer(KIND_POP, 0);
    offer(KIND_POP, 0);

    seg_no = 0;
    while (items_sent < TOTAL_ITEMS) begin
      if (seg_no == 0) seg = SEG_FILL;
      else if (seg_no == 1) seg = SEG_DRAIN;
      else if (items_sent > TOTAL_ITEMS - 400) seg = SEG_MIXED;
      else seg = segment_t'($urandom_range(0, 2));
      style = value_style_t'($urandom_range(0, 3));
      if (seg_no == 0 || seg_no == 4) holdoffs_asked++;
      if (seg_no == 3) hold_until_drained();
      case (seg)
        SEG_FILL: begin
          while (stack_fill < STACK_DEPTH) begin
            pct = $urandom_range(0, 99);
            offer((pct < 85) ? KIND_PUSH : KIND_POP, pick_value(style));
          end
          // pushes onto the full stack must be dropped
          repeat ($urandom_range(1, 3)) offer(KIND_PUSH, pick_value(style));
        end
        SEG_DRAIN: begin
          while (stack_fill > 0) begin
            pct = $urandom_range(0, 99);
            offer((pct < 85) ? KIND_POP : KIND_PUSH, pick_value(style));
          end
          repeat ($urandom_range(1, 2)) offer(KIND_POP, $urandom);
        end
        default: begin
          repeat ($urandom_range(40, 120)) begin
            pct = $urandom_range(0, 99);
            offer((pct < 50) ? KIND_PUSH : KIND_POP, pick_value(style));
          end
        end
      endcase
      seg_no++;
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
